// File: sv/edid_phys_addr_patch_checksum_defines.svh
// Assertion macros for the EDID physical address patcher.
`ifndef EDID_PHYS_ADDR_PATCH_CHECKSUM_DEFINES_SVH
`define EDID_PHYS_ADDR_PATCH_CHECKSUM_DEFINES_SVH

// Clocked property with active-low reset disable.
`define EDPA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define EDPA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/edpa_pkg.sv
// Package: types and constants of the EDID physical address patcher.
package edpa_pkg;

    localparam int EDPA_MAX_BLOCKS = 256;
    localparam int BLOCK_BYTES     = 128;

    localparam logic [7:0] EXT_COUNT_ONE = 8'h01;
    localparam logic [7:0] CEA_TAG_BYTE  = 8'h02;
    localparam logic [7:0] CEA_REV_BYTE  = 8'h03;
    localparam logic [2:0] SPA_TAG       = 3'd3;
    localparam logic [4:0] SPA_MIN_LEN   = 5'd5;
    localparam logic [15:0] NO_ADDR      = 16'hffff;

    localparam int POS_EXT_COUNT  = 126;
    localparam int POS_CEA_TAG    = 128;
    localparam int POS_CEA_REV    = 129;
    localparam int POS_DTD_OFFSET = 130;
    localparam int POS_FIRST_HDR  = 132;
    localparam int POS_MIN_FOUND  = 255;

    localparam logic CFG_NEW_ADDR = 1'b0;
    localparam logic CFG_FIX_CSUM = 1'b1;

    typedef struct packed {
        logic [7:0] edid_byte;
        logic       final_byte;
    } edpa_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        block_end;
        logic        checksum_bad;
        logic [15:0] found_phys_addr;
        logic        too_long;
        logic        last;
    } edpa_out_t;

    typedef struct packed {
        logic [15:0] new_phys_addr;
        logic        fix_checksums;
    } edpa_cfg_t;

endpackage

// File: sv/edpa_core.sv
// Per-byte datapath: header parse, address capture/patch, checksum repair.
module edpa_core import edpa_pkg::*; #(
    parameter int MAX_BLOCKS = EDPA_MAX_BLOCKS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  edpa_cfg_t cfg,
    input  logic      step_en,
    input  edpa_in_t  item,
    output edpa_out_t result
);

    localparam int POS_W = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);
    localparam logic [POS_W-1:0] LIMIT = POS_W'(MAX_BLOCKS * BLOCK_BYTES);

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [7:0]       block_sum_reg, block_sum_next;
    logic             single_ext_reg, single_ext_next;
    logic             cea_ok_reg, cea_ok_next;
    logic [8:0]       dbe_reg, dbe_next;
    logic [POS_W-1:0] next_hdr_reg, next_hdr_next;
    logic [POS_W-1:0] spa_loc_reg, spa_loc_next;
    logic             spa_found_reg, spa_found_next;
    logic [15:0]      cap_addr_reg, cap_addr_next;

    always_comb begin
        logic [POS_W-1:0] pos;
        logic [7:0]       b;
        logic [7:0]       ob;
        logic [POS_W-1:0] hi_next;
        logic             patch;
        logic             redo;

        pos   = byte_position_reg;
        b     = item.edid_byte;
        ob    = b;
        patch = (cfg.new_phys_addr != NO_ADDR);
        redo  = 1'b0;

        byte_position_next = byte_position_reg;
        block_sum_next     = block_sum_reg;
        single_ext_next    = single_ext_reg;
        cea_ok_next        = cea_ok_reg;
        dbe_next           = dbe_reg;
        next_hdr_next      = next_hdr_reg;
        spa_loc_next       = spa_loc_reg;
        spa_found_next     = spa_found_reg;
        cap_addr_next      = cap_addr_reg;

        result.block_end       = 1'b0;
        result.checksum_bad    = 1'b0;
        result.found_phys_addr = NO_ADDR;
        result.too_long        = 1'b0;
        result.last            = item.final_byte;

        if (pos >= LIMIT) begin
            result.too_long = 1'b1;
        end else begin
            if (pos == POS_W'(POS_EXT_COUNT)) begin
                single_ext_next = (b == EXT_COUNT_ONE);
            end
            if (pos == POS_W'(POS_CEA_TAG)) begin
                cea_ok_next = (b == CEA_TAG_BYTE);
            end
            if (pos == POS_W'(POS_CEA_REV)) begin
                cea_ok_next = cea_ok_reg && (b == CEA_REV_BYTE);
            end
            if (pos == POS_W'(POS_DTD_OFFSET)) begin
                dbe_next = {2'b01, b[6:0]};
            end

            if (single_ext_next && cea_ok_next && !spa_found_reg && pos == next_hdr_reg &&
                pos < POS_W'(dbe_next)) begin
                if (b[7:5] == SPA_TAG && b[4:0] >= SPA_MIN_LEN) begin
                    spa_found_next = 1'b1;
                    spa_loc_next   = pos + POS_W'(4);
                end else begin
                    next_hdr_next = pos + POS_W'(b[4:0]) + POS_W'(1);
                end
            end

            if (spa_found_next && pos == spa_loc_next) begin
                cap_addr_next[15:8] = b;
                if (patch) begin
                    ob = cfg.new_phys_addr[15:8];
                end
            end
            if (spa_found_next && pos == spa_loc_next + POS_W'(1)) begin
                cap_addr_next[7:0] = b;
                if (patch) begin
                    ob = cfg.new_phys_addr[7:0];
                end
            end

            if (&pos[6:0]) begin
                redo = cfg.fix_checksums ||
                       (patch && spa_found_next && pos[POS_W-1:7] == spa_loc_next[POS_W-1:7]);
                result.block_end = 1'b1;
                if (redo) begin
                    ob = 8'd0 - block_sum_reg;
                end
                result.checksum_bad = ((block_sum_reg + ob) != 8'd0);
                block_sum_next      = 8'd0;
            end else begin
                block_sum_next = block_sum_reg + ob;
            end
            byte_position_next = pos + POS_W'(1);
        end

        hi_next = spa_loc_next + POS_W'(1);
        if (item.final_byte) begin
            if (spa_found_next && pos >= POS_W'(POS_MIN_FOUND) && hi_next <= pos &&
                hi_next < LIMIT) begin
                result.found_phys_addr = cap_addr_next;
            end
            byte_position_next = '0;
            block_sum_next     = 8'd0;
            single_ext_next    = 1'b0;
            cea_ok_next        = 1'b0;
            dbe_next           = 9'd0;
            next_hdr_next      = POS_W'(POS_FIRST_HDR);
            spa_loc_next       = '0;
            spa_found_next     = 1'b0;
            cap_addr_next      = NO_ADDR;
        end

        result.out_byte = ob;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
            block_sum_reg     <= 8'd0;
            single_ext_reg    <= 1'b0;
            cea_ok_reg        <= 1'b0;
            dbe_reg           <= 9'd0;
            next_hdr_reg      <= POS_W'(POS_FIRST_HDR);
            spa_loc_reg       <= '0;
            spa_found_reg     <= 1'b0;
            cap_addr_reg      <= NO_ADDR;
        end else if (step_en) begin
            byte_position_reg <= byte_position_next;
            block_sum_reg     <= block_sum_next;
            single_ext_reg    <= single_ext_next;
            cea_ok_reg        <= cea_ok_next;
            dbe_reg           <= dbe_next;
            next_hdr_reg      <= next_hdr_next;
            spa_loc_reg       <= spa_loc_next;
            spa_found_reg     <= spa_found_next;
            cap_addr_reg      <= cap_addr_next;
        end
    end

endmodule

// File: sv/edid_phys_addr_patch_checksum.sv
// Top level: EDID CEC physical address patcher with checksum repair.
//
// Input channel s_valid/s_ready/s_data carries one EDID byte per transaction,
// in address order; s_data.final_byte marks the last byte of one EDID.
// Output channel m_valid/m_ready/m_data returns exactly one result per input
// byte, in order: the byte after address substitution and checksum repair,
// block-end and checksum flags, the unpatched address on the last byte.
// Configuration: cfg_we with cfg_index/cfg_wdata writes new_phys_addr
// (index 0) or fix_checksums (index 1); write only while idle.
// m_valid rises once an accepted byte has passed the input register and then
// the result register. Throughput: one byte per cycle while m_ready is high,
// set by the single pass of header compare, 8-bit sum and substitution
// between the two registers.
// Reset (aresetn low, synchronous) empties both registers, restores the
// parse state and sets new_phys_addr to 0xffff, fix_checksums to 0.
// When m_ready is low the result holds; the input register still takes one
// more transaction, then s_ready falls until the result is taken.
module edid_phys_addr_patch_checksum import edpa_pkg::*; #(
    parameter int MAX_BLOCKS = EDPA_MAX_BLOCKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  edpa_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output edpa_out_t   m_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic      in_valid_reg;
    edpa_in_t  in_data_reg;
    logic      out_valid_reg;
    edpa_out_t out_data_reg;
    edpa_cfg_t cfg_reg;
    edpa_out_t result;
    logic      step_en;

    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.new_phys_addr <= NO_ADDR;
            cfg_reg.fix_checksums <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NEW_ADDR: cfg_reg.new_phys_addr <= cfg_wdata;
                CFG_FIX_CSUM: cfg_reg.fix_checksums <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step_en) begin
            out_data_reg <= result;
        end
    end

    edpa_core #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step_en (step_en),
        .item    (in_data_reg),
        .result  (result)
    );

endmodule

// File: sv/edpa_checker.sv
// Port-level assertions for the EDID physical address patcher, with bind.
`include "edid_phys_addr_patch_checksum_defines.svh"

module edpa_checker import edpa_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input edpa_out_t m_data
);

    `EDPA_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    `EDPA_ASSERT_IMP(a_addr_only_last, aclk, aresetn, m_valid && !m_data.last, m_data.found_phys_addr == NO_ADDR, "address reported before last byte")
    `EDPA_ASSERT_IMP(a_long_no_block, aclk, aresetn, m_valid && m_data.too_long, !m_data.block_end && !m_data.checksum_bad, "overlong byte flagged as block end")
    `EDPA_ASSERT_IMP(a_bad_at_end, aclk, aresetn, m_valid && !m_data.block_end, !m_data.checksum_bad, "checksum flag off block end")

endmodule

bind edid_phys_addr_patch_checksum edpa_checker u_edpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
